// ----- design/delta_histogram_prefetcher_defines.svh -----
// Assertion macros for the delta histogram prefetcher
`ifndef DELTA_HISTOGRAM_PREFETCHER_DEFINES_SVH
`define DELTA_HISTOGRAM_PREFETCHER_DEFINES_SVH

// Condition must hold at every clock edge out of reset
`define DHP_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("dhp assertion failed");

// Consequent must hold in the cycle after the antecedent
`define DHP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dhp assertion failed");

`endif

// ----- design/dhp_pkg.sv -----
package dhp_pkg;

  localparam int unsigned ADDR_W        = 64;
  localparam int unsigned DELTA_W       = 7;
  localparam int unsigned MAG_W         = 6;
  localparam int unsigned BLOCK_SHIFT   = 6;
  localparam int unsigned PAGE_SHIFT    = 12;
  localparam int unsigned DELTA_BINS    = 127;
  localparam int unsigned BIN_W         = 7;
  localparam int unsigned HISTORY_DEPTH = 16;
  localparam int unsigned COUNT_WIDTH   = 16;

  localparam logic [BIN_W-1:0] DELTA_OFFSET = 7'd63;
  localparam logic signed [DELTA_W-1:0] DELTA_NO_BIN = -7'sd64;

  typedef struct packed {
    logic                      found;
    logic signed [DELTA_W-1:0] delta;
  } sel_t;

endpackage

// ----- design/dhp_ram.sv -----
module dhp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dhp_delta_select.sv -----
module dhp_delta_select #(
  parameter int unsigned HISTORY_DEPTH = dhp_pkg::HISTORY_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [dhp_pkg::ADDR_W-1:0]  addr_i,
  output dhp_pkg::sel_t               sel_o
);

  localparam int unsigned LEVELS = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0;
  localparam int unsigned LEAVES = 1 << LEVELS;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  typedef struct packed {
    logic                               valid;
    logic [dhp_pkg::MAG_W-1:0]          mag;
    logic signed [dhp_pkg::DELTA_W-1:0] delta;
  } node_t;

  logic [dhp_pkg::ADDR_W-1:0] hist_q [HISTORY_DEPTH];
  logic                       started_q;
  node_t                      node [NODES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (push_i) begin
      started_q <= 1'b1;
      hist_q[0] <= addr_i;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  // leaves: same-page block delta, floor division by the block size
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < HISTORY_DEPTH) begin : g_real
      logic                                  same_page;
      logic [dhp_pkg::PAGE_SHIFT:0]          diff;
      logic signed [dhp_pkg::DELTA_W-1:0]    d;
      logic signed [dhp_pkg::DELTA_W-1:0]    neg_d;

      assign same_page = hist_q[i][dhp_pkg::ADDR_W-1:dhp_pkg::PAGE_SHIFT]
                         == addr_i[dhp_pkg::ADDR_W-1:dhp_pkg::PAGE_SHIFT];
      assign diff  = {1'b0, addr_i[dhp_pkg::PAGE_SHIFT-1:0]}
                   - {1'b0, hist_q[i][dhp_pkg::PAGE_SHIFT-1:0]};
      assign d     = diff[dhp_pkg::PAGE_SHIFT:dhp_pkg::BLOCK_SHIFT];
      assign neg_d = -d;

      assign node[LEAVES-1+i].valid = started_q && same_page && (d != dhp_pkg::DELTA_NO_BIN);
      assign node[LEAVES-1+i].mag   = d[dhp_pkg::DELTA_W-1] ? neg_d[dhp_pkg::MAG_W-1:0]
                                                            : d[dhp_pkg::MAG_W-1:0];
      assign node[LEAVES-1+i].delta = d;
    end else begin : g_pad
      assign node[LEAVES-1+i] = '0;
    end
  end

  // min-magnitude tree, lower index (newer) wins ties
  for (genvar k = 0; k < LEAVES - 1; k++) begin : g_tree
    node_t l_node;
    node_t r_node;
    assign l_node = node[2*k+1];
    assign r_node = node[2*k+2];
    assign node[k] = (l_node.valid && (!r_node.valid || (l_node.mag <= r_node.mag)))
                   ? l_node : r_node;
  end

  assign sel_o.found = node[0].valid;
  assign sel_o.delta = node[0].valid ? node[0].delta : '0;

endmodule

// ----- design/delta_histogram_prefetcher.sv -----
// Block-delta frequency prefetcher. Each request on the slave side carries one
// demand access address; each yields exactly one result: access address plus the
// most frequent block delta times 64 (wrapping), the smallest-magnitude same-page
// delta against the address history, and a flag saying whether one was found.
// A request does the history compare and the histogram memory read in the accept
// cycle, then the count write-back and best-delta update in the update state. The
// next request can be accepted in the cycle after the write-back, so no request is
// taken before the last one is done; the histogram read-modify-write limits the
// rate. A result waiting on the master side holds the write-back stage, and the
// slave side with it, until the result is taken. The histogram needs no clearing
// pass after reset: each bin has a valid bit and reads as zero until first written.
module delta_histogram_prefetcher #(
  parameter int unsigned HISTORY_DEPTH = dhp_pkg::HISTORY_DEPTH,
  parameter int unsigned COUNT_WIDTH   = dhp_pkg::COUNT_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] access_addr
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [63:0] prefetch_addr, [70:64] chosen_delta, [71] 0
  output logic        m_axis_tuser_o    // [0] delta_found
);

`include "delta_histogram_prefetcher_defines.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;
  localparam int unsigned EXT_W = dhp_pkg::ADDR_W - dhp_pkg::DELTA_W - dhp_pkg::BLOCK_SHIFT;

  logic state_q, state_d;
  logic s_fire, upd_go;

  dhp_pkg::sel_t sel;

  logic [dhp_pkg::ADDR_W-1:0]         addr_q;
  logic                               found_q;
  logic signed [dhp_pkg::DELTA_W-1:0] delta_q;
  logic [dhp_pkg::BIN_W-1:0]          bin_q, bin_d;

  logic [dhp_pkg::DELTA_BINS-1:0] bin_valid_q;
  logic [COUNT_WIDTH-1:0]         ram_rdata, cnt, cnt_inc;
  logic                           ram_we, improve;

  logic [COUNT_WIDTH-1:0]             best_count_q;
  logic signed [dhp_pkg::DELTA_W-1:0] best_delta_q, best_delta_d;

  logic                               out_valid_q;
  logic [dhp_pkg::ADDR_W-1:0]         out_addr_q, out_addr_d;
  logic                               out_found_q;
  logic signed [dhp_pkg::DELTA_W-1:0] out_delta_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign upd_go = (state_q == ST_UPD) && (!out_valid_q || m_axis_tready_i);

  dhp_delta_select #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_select (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(s_fire),
    .addr_i(s_axis_tdata_i),
    .sel_o (sel)
  );

  assign bin_d = sel.delta + dhp_pkg::DELTA_OFFSET;

  dhp_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(dhp_pkg::DELTA_BINS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(bin_q),
    .wdata_i(cnt_inc),
    .re_i   (s_fire),
    .raddr_i(bin_d),
    .rdata_o(ram_rdata)
  );

  assign cnt          = bin_valid_q[bin_q] ? ram_rdata : '0;
  assign cnt_inc      = (&cnt) ? cnt : cnt + 1'b1;
  assign ram_we       = upd_go && found_q;
  assign improve      = found_q && (cnt_inc > best_count_q);
  assign best_delta_d = improve ? delta_q : best_delta_q;
  assign out_addr_d   = addr_q + {{EXT_W{best_delta_d[dhp_pkg::DELTA_W-1]}}, best_delta_d,
                                  {dhp_pkg::BLOCK_SHIFT{1'b0}}};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bin_valid_q  <= '0;
      best_count_q <= '0;
      best_delta_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        bin_valid_q[bin_q] <= 1'b1;
      end
      if (upd_go && improve) begin
        best_count_q <= cnt_inc;
        best_delta_q <= delta_q;
      end
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      addr_q  <= s_axis_tdata_i;
      found_q <= sel.found;
      delta_q <= sel.delta;
      bin_q   <= bin_d;
    end
    if (upd_go) begin
      out_addr_q  <= out_addr_d;
      out_found_q <= found_q;
      out_delta_q <= delta_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_delta_q, out_addr_q};
  assign m_axis_tuser_o  = out_found_q;

  `DHP_ASSERT(a_we_in_upd, !ram_we || (state_q == ST_UPD))
  `DHP_ASSERT_NEXT(a_accept_to_upd, s_fire, state_q == ST_UPD)
  `DHP_ASSERT_NEXT(a_best_monotonic, 1'b1, best_count_q >= $past(best_count_q))
  `DHP_ASSERT(a_no_minus64, !(found_q && (state_q == ST_UPD)) || (delta_q != dhp_pkg::DELTA_NO_BIN))

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dhp_pkg::*;

  localparam int DIR_N        = 17;
  localparam int RANDOM_ITEMS = 433;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [ADDR_W-1:0]         prefetch;
    logic                      found;
    logic signed [DELTA_W-1:0] delta;
  } pf_result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              typed;
    pf_result_t        want;
  } access_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic [63:0] s_tdata;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic        m_tready;
  logic [71:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  delta_histogram_prefetcher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // predictor state
  logic [ADDR_W-1:0]         hist_q [HISTORY_DEPTH];
  logic                      hist_live;
  logic [COUNT_WIDTH-1:0]    bin_count [DELTA_BINS];
  logic [COUNT_WIDTH-1:0]    top_count;
  logic signed [DELTA_W-1:0] top_delta;

  pf_result_t  pending_prefetches [$];
  logic [51:0] page_pool [4];
  bit          burst_mode;
  bit          hold_pending;
  int          n_sent;
  int          n_checked;
  int          n_found;
  int          n_errors;

  access_row_t directed_rows [DIR_N] = '{
    // first access: no compare, best delta still zero
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 7'sd0}},
    // matches the never-written zero entries, delta +5 becomes best
    '{64'h0000_0000_0000_0140, 1'b1, '{64'h0000_0000_0000_0280, 1'b1, 7'sd5}},
    // only same-page entry sits at delta -64: no bin, no match
    '{64'hFFFF_FFFF_FFFF_F000, 1'b1, '{64'hFFFF_FFFF_FFFF_F140, 1'b0, 7'sd0}},
    '{64'hFFFF_FFFF_FFFF_FFC0, 1'b0, '0},
    '{64'h1234_5678_9ABC_D000, 1'b0, '0},
    '{64'h1234_5678_9ABC_DFFF, 1'b0, '0},
    '{64'h1234_5678_9ABC_EFC0, 1'b0, '0},
    '{64'h1234_5678_9ABC_E001, 1'b0, '0},
    '{64'h1234_5678_9ABC_E0C0, 1'b0, '0},
    '{64'h1234_5678_9ABC_E080, 1'b0, '0},
    '{64'h1234_5678_9ABC_E080, 1'b0, '0},
    '{64'h0000_0000_0000_0000, 1'b0, '0},
    '{64'h0000_0000_0000_003F, 1'b0, '0},
    '{64'h8000_0000_0000_0000, 1'b0, '0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0}
  };

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic pf_result_t predict_prefetch(input logic [ADDR_W-1:0] addr);
    pf_result_t        r;
    logic [ADDR_W-1:0] prev;
    logic [ADDR_W-1:0] offs;
    int                best_mag;
    int                pick;
    int                lo_a;
    int                lo_p;
    int                d;
    int                mag;
    int                bin;
    r.found  = 1'b0;
    r.delta  = '0;
    best_mag = 64;
    pick     = 0;
    if (hist_live) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        prev = hist_q[i];
        if (addr[ADDR_W-1:PAGE_SHIFT] == prev[ADDR_W-1:PAGE_SHIFT]) begin
          lo_a = int'(addr[PAGE_SHIFT-1:0]);
          lo_p = int'(prev[PAGE_SHIFT-1:0]);
          if (lo_a >= lo_p) begin
            d = (lo_a - lo_p) >> BLOCK_SHIFT;
          end else begin
            d = -((lo_p - lo_a + 63) >> BLOCK_SHIFT);
          end
          mag = (d < 0) ? -d : d;
          if (mag < best_mag) begin
            best_mag = mag;
            pick     = d;
            r.found  = 1'b1;
          end
        end
      end
    end
    if (r.found) begin
      r.delta = pick[DELTA_W-1:0];
      bin = pick + 63;
      if (bin_count[bin] != {COUNT_WIDTH{1'b1}}) bin_count[bin]++;
      if (bin_count[bin] > top_count) begin
        top_count = bin_count[bin];
        top_delta = pick[DELTA_W-1:0];
      end
    end
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist_q[i] = hist_q[i-1];
    hist_q[0] = addr;
    hist_live = 1'b1;
    offs = {{(ADDR_W-DELTA_W){top_delta[DELTA_W-1]}}, top_delta};
    r.prefetch = addr + (offs << BLOCK_SHIFT);
    return r;
  endfunction

  // mostly same-page strides and reuse, so the history compare finds matches
  function automatic logic [ADDR_W-1:0] next_access(input logic [ADDR_W-1:0] last);
    logic [ADDR_W-1:0] a;
    int                sel;
    int                stride;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      stride = int'($urandom_range(0, 16)) - 8;
      a = last + 64'(longint'(stride) * 64);
      a[5:0] = 6'($urandom_range(0, 63));
    end else if (sel < 80) begin
      a = {page_pool[$urandom_range(0, 3)], 12'($urandom_range(0, 4095))};
    end else if (sel < 90) begin
      a = {$urandom(), $urandom()};
    end else begin
      a = hist_q[$urandom_range(0, HISTORY_DEPTH - 1)] ^ 64'($urandom_range(0, 255));
    end
    return a;
  endfunction

  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic typed,
                             input pf_result_t typed_want);
    pf_result_t pred;
    int         gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_prefetch(addr);
    if (typed) pred = typed_want;
    pending_prefetches = {pending_prefetches, pred};
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    n_errors++;
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
  endfunction

  always @(posedge clk_i) begin
    pf_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      n_checked++;
      if (m_axis_tuser_o) n_found++;
      if (pending_prefetches.size() == 0) begin
        note_mismatch("unexpected request", '0, m_axis_tdata_o[63:0]);
      end else begin
        want = pending_prefetches.pop_front();
        if (m_axis_tdata_o[63:0] !== want.prefetch)
          note_mismatch("prefetch_addr", want.prefetch, m_axis_tdata_o[63:0]);
        if (m_axis_tuser_o !== want.found)
          note_mismatch("delta_found", 64'(want.found), 64'(m_axis_tuser_o));
        if (m_axis_tdata_o[70:64] !== want.delta)
          note_mismatch("chosen_delta", 64'(want.delta), 64'(m_axis_tdata_o[70:64]));
      end
    end
  end

  // receiver
  initial begin
    int stall;
    m_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 8);
      if (hold_pending) begin
        stall        = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    #15_000_000;
    $display("timeout with %0d requests outstanding", pending_prefetches.size());
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] addr;
    int                waited;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    rst_ni       = 1'b0;
    burst_mode   = 1'b0;
    hold_pending = 1'b0;
    n_sent       = 0;
    n_checked    = 0;
    n_found      = 0;
    n_errors     = 0;
    for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] = '0;
    for (int i = 0; i < DELTA_BINS; i++) bin_count[i] = '0;
    hist_live    = 1'b0;
    top_count    = '0;
    top_delta    = '0;
    page_pool[0] = '0;
    page_pool[1] = '1;
    page_pool[2] = {20'($urandom()), $urandom()};
    page_pool[3] = {20'($urandom()), $urandom()};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_N; i++)
      send_access(directed_rows[i].addr, directed_rows[i].typed, directed_rows[i].want);

    addr = directed_rows[DIR_N-1].addr;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      burst_mode = (i % 100) >= 80;
      if (i == 200) hold_pending = 1'b1;
      addr = next_access(addr);
      send_access(addr, 1'b0, '0);
    end
    burst_mode = 1'b0;
    s_tvalid <= 1'b0;

    waited = 0;
    while (pending_prefetches.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);

    if (pending_prefetches.size() != 0) begin
      $display("%0t ns: %0d expected requests never arrived", $time,
               pending_prefetches.size());
      n_errors++;
    end

    $display("%0d accesses sent: %0d directed, %0d random with bursts and a long hold",
             n_sent, DIR_N, RANDOM_ITEMS);
    $display("%0d prefetches checked, %0d with a same-page delta, %0d mismatches",
             n_checked, n_found, n_errors);
    if (n_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
